// ----- hw/rtl/taf_pkg.sv -----
// Shared types, constants and helper functions of the tracklet attributable fit unit.
package taf_pkg;

  localparam int MAX_OBS_DEF = 64;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FEW    = 2'd1;
  localparam logic [1:0] STAT_SPREAD = 2'd2;
  localparam logic [1:0] STAT_MANY   = 2'd3;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [62:0] RATE_CAP = 63'h1000_0000_0000_0000;
  localparam logic [62:0] QUOT_CAP = 63'h4000_0000_0000_0000;

  localparam logic [5:0] RATE_SHIFT = 6'd26;
  localparam logic [5:0] UNIT_SHIFT = 6'd50;
  localparam logic [5:0] MEAN_SHIFT = 6'd0;

  localparam logic [7:0] MUL_STEPS  = 8'd4;
  localparam logic [7:0] DIV_BITS   = 8'd128;
  localparam logic [7:0] SQRT_STEPS = 8'd64;

  typedef struct packed {
    logic signed [47:0] obs_time;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [47:0] pos_z;
    logic signed [47:0] vel_x;
    logic signed [47:0] vel_y;
    logic signed [47:0] vel_z;
    logic               last_obs;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]  status;
    logic signed [47:0] mean_time;
    logic        [1:0]  axis;
    logic signed [31:0] los_unit;
    logic signed [47:0] los_rate;
    logic signed [47:0] mean_pos;
    logic signed [47:0] mean_vel;
    logic               last_result;
  } out_item_t;

  typedef enum logic [1:0] {ALU_MUL, ALU_DIV, ALU_SQRT} alu_op_t;

  typedef enum logic [1:0] {AS_IDLE, AS_RUN, AS_FIN} alu_st_t;

  typedef struct packed {
    logic                start;
    alu_op_t             op;
    logic signed [127:0] a;
    logic        [127:0] b;
    logic        [5:0]   shift;
    logic        [62:0]  cap;
  } alu_cmd_t;

  typedef struct packed {
    logic                done;
    logic signed [127:0] res;
  } alu_rsp_t;

  typedef struct packed {
    logic        [1:0]       status;
    logic signed [47:0]      tm;
    logic        [2:0][31:0] u;
    logic        [2:0][47:0] perp;
    logic        [2:0][47:0] mp;
    logic        [2:0][47:0] mv;
  } emit_bank_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SUM, ST_MSQ, ST_MDO, ST_SPA, ST_SPB, ST_STAT, ST_NA, ST_NB, ST_ETA,
    ST_Q2, ST_SQRT, ST_UNIT, ST_DOT, ST_P, ST_PERP, ST_TM, ST_MP, ST_MV, ST_LOAD
  } fsm_t;

  function automatic logic signed [63:0] sat_w(input logic signed [128:0] v,
                                               input int unsigned w);
    logic signed [128:0] hi;
    logic signed [128:0] lo;
    hi = (129'sd1 <<< (w - 1)) - 129'sd1;
    lo = -(129'sd1 <<< (w - 1));
    if (v > hi) return hi[63:0];
    else if (v < lo) return lo[63:0];
    else return v[63:0];
  endfunction

  function automatic logic signed [128:0] rnd30(input logic signed [127:0] v);
    return (129'(v) + 129'sd536870912) >>> 30;
  endfunction

endpackage

// ----- hw/rtl/taf_in_if.sv -----
// Observation channel: valid, ready and one observation as payload.
interface taf_in_if import taf_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/taf_out_if.sv -----
// Result channel: valid, ready and one result as payload.
interface taf_out_if import taf_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

// ----- hw/rtl/taf_alu.sv -----
// Shared iterative unit: 64x64 multiply, rounded capped division and integer square root.
module taf_alu import taf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  alu_cmd_t cmd,
  output alu_rsp_t rsp
);

  alu_st_t       ast, ast_next;
  alu_op_t       op;
  logic [7:0]    cnt;
  logic          neg;
  logic          sat;
  logic [127:0]  nm;
  logic [127:0]  den;
  logic [127:0]  r;
  logic [63:0]   q;
  logic [62:0]   cap;

  logic [63:0]   a64, b64, mag_a64, mag_b64;
  logic [127:0]  mag_num;
  logic [79:0]   prod;
  logic [128:0]  r2, rd;
  logic          div_ge, div_sat;
  logic [63:0]   qn;
  logic [127:0]  rem2, trial;
  logic          sq_ge;
  logic          rnd_inc;
  logic [63:0]   qq, qs;

  always_comb begin
    a64     = cmd.a[63:0];
    b64     = cmd.b[63:0];
    mag_a64 = a64[63] ? -a64 : a64;
    mag_b64 = b64[63] ? -b64 : b64;
    mag_num = cmd.a[127] ? -cmd.a : cmd.a;
    prod    = 80'(den[63:0]) * 80'(nm[127:112]);
    r2      = {r, nm[127]};
    div_ge  = r2 >= {1'b0, den};
    rd      = div_ge ? r2 - {1'b0, den} : r2;
    qn      = {q[62:0], div_ge};
    div_sat = qn > {1'b0, cap};
    rem2    = {r[125:0], nm[127:126]};
    trial   = {62'b0, q, 2'b01};
    sq_ge   = rem2 >= trial;
    rnd_inc = !sat && ({r, 1'b0} >= {1'b0, den}) && (q < {1'b0, cap});
    qq      = q + 64'(rnd_inc);
    qs      = neg ? -qq : qq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ast <= AS_IDLE;
    end else begin
      ast <= ast_next;
    end
  end

  always_comb begin
    ast_next = ast;
    rsp.done = 1'b0;
    rsp.res  = '0;
    case (ast)
      AS_IDLE: begin
        if (cmd.start) ast_next = AS_RUN;
      end
      AS_RUN: begin
        if (cnt == 8'd1) ast_next = AS_FIN;
      end
      AS_FIN: begin
        ast_next = AS_IDLE;
        rsp.done = 1'b1;
        case (op)
          ALU_MUL:  rsp.res = neg ? -r : r;
          ALU_DIV:  rsp.res = 128'(signed'(qs));
          ALU_SQRT: rsp.res = {64'b0, q};
          default:  rsp.res = '0;
        endcase
      end
      default: ast_next = AS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (ast)
      AS_IDLE: begin
        if (cmd.start) begin
          op  <= cmd.op;
          r   <= '0;
          q   <= '0;
          sat <= 1'b0;
          cap <= cmd.cap;
          case (cmd.op)
            ALU_MUL: begin
              den <= {64'b0, mag_a64};
              nm  <= {mag_b64, 64'b0};
              neg <= a64[63] ^ b64[63];
              cnt <= MUL_STEPS;
            end
            ALU_DIV: begin
              nm  <= mag_num;
              den <= cmd.b;
              neg <= cmd.a[127];
              cnt <= DIV_BITS + 8'(cmd.shift);
            end
            default: begin
              nm  <= cmd.a;
              den <= '0;
              neg <= 1'b0;
              cnt <= SQRT_STEPS;
            end
          endcase
        end
      end
      AS_RUN: begin
        cnt <= cnt - 8'd1;
        case (op)
          ALU_MUL: begin
            r  <= (r << 16) + 128'(prod);
            nm <= nm << 16;
          end
          ALU_DIV: begin
            r   <= rd[127:0];
            q   <= div_sat ? {1'b0, cap} : qn;
            sat <= sat | div_sat;
            nm  <= nm << 1;
          end
          default: begin
            r  <= sq_ge ? rem2 - trial : rem2;
            q  <= {q[62:0], sq_ge};
            nm <= nm << 2;
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/taf_emit.sv -----
// Result stage: holds one tracklet's results and sends them as beats.
module taf_emit import taf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  emit_bank_t       bank_in,
  output logic             busy,
  taf_out_if.source        fit
);

  emit_bank_t bank;
  logic [1:0] idx;
  logic       ok;
  logic       last;

  always_comb begin
    ok   = bank.status == STAT_OK;
    last = !ok || (idx == AXIS_Z);
    fit.valid            = busy;
    fit.item.status      = bank.status;
    fit.item.mean_time   = ok ? bank.tm : '0;
    fit.item.axis        = ok ? idx : AXIS_X;
    fit.item.los_unit    = ok ? bank.u[idx] : '0;
    fit.item.los_rate    = ok ? bank.perp[idx] : '0;
    fit.item.mean_pos    = ok ? bank.mp[idx] : '0;
    fit.item.mean_vel    = ok ? bank.mv[idx] : '0;
    fit.item.last_result = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= AXIS_X;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= AXIS_X;
    end else if (busy && fit.ready) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bank <= bank_in;
    end
  end

endmodule

// ----- hw/rtl/tracklet_attributable_fit_unit.sv -----
// Top level: tracklet sums, closing fit sequencer, shared arithmetic unit and result stage.
//
//   channel  dir   beat            accepted when
//   obs      in    one observation obs.valid && obs.ready
//   fit      out   one result      fit.valid && fit.ready
//
// Each observation takes four 64x64 products on the shared unit, 16 bits a step.
// The observation marked last starts the closing fit, which runs up to thirteen bit-serial
// divisions and one square root in the same unit.
// Synchronous reset clears the sequencer, the sums and the result stage.
// A stalled result beat holds only the result stage; the next tracklet's observations are
// taken meanwhile, and its closing fit waits for the stage to empty before handing over.
module tracklet_attributable_fit_unit import taf_pkg::*; #(
  parameter int MAX_OBS = MAX_OBS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  taf_in_if.sink    obs,
  taf_out_if.source fit
);

  localparam int CW = $clog2(MAX_OBS + 1);

  fsm_t               state, state_next;
  logic               issued, issued_next;
  logic [1:0]         j, j_next;
  logic               j_last;
  logic               alu_go;
  alu_cmd_t           cmd;
  alu_rsp_t           rsp;
  logic               emit_load;
  logic               emit_busy;
  emit_bank_t         bank;

  in_item_t           item;
  logic signed [48:0] d, d_c;
  logic signed [47:0] first;
  logic [CW-1:0]      count;
  logic               ovf;
  logic signed [63:0] so, soq;
  logic signed [39:0] sd [3];
  logic signed [63:0] sdo [3];
  logic signed [55:0] sp [3];
  logic signed [55:0] sv [3];
  logic signed [127:0] spread, tmpa, q2, dot;
  logic signed [61:0] eta [3];
  logic [60:0]        len;
  logic signed [31:0] u [3];
  logic signed [63:0] p;
  logic signed [47:0] perp [3];
  logic signed [47:0] mp [3];
  logic signed [47:0] mv [3];
  logic signed [47:0] tm;
  logic [1:0]         status, status_c;
  logic signed [31:0] dir_sel;
  logic [63:0]        n64;

  taf_alu u_alu (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .rsp (rsp)
  );

  taf_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (emit_load),
    .bank_in (bank),
    .busy    (emit_busy),
    .fit     (fit)
  );

  always_comb begin
    j_last = j == 2'd2;
    n64    = 64'(count);
    d_c    = (count == '0) ? '0 : 49'(item.obs_time) - 49'(first);
    case (j)
      2'd0:    dir_sel = item.dir_x;
      2'd1:    dir_sel = item.dir_y;
      default: dir_sel = item.dir_z;
    endcase
    if (ovf) status_c = STAT_MANY;
    else if (count < CW'(2)) status_c = STAT_FEW;
    else if (spread <= 128'sd0) status_c = STAT_SPREAD;
    else status_c = STAT_OK;
    bank.status = status;
    bank.tm     = tm;
    for (int k = 0; k < 3; k++) begin
      bank.u[k]    = u[k];
      bank.perp[k] = perp[k];
      bank.mp[k]   = mp[k];
      bank.mv[k]   = mv[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
      j      <= 2'd0;
    end else begin
      state  <= state_next;
      issued <= issued_next;
      j      <= j_next;
    end
  end

  always_comb begin
    state_next  = state;
    issued_next = issued;
    j_next      = j;
    cmd         = '0;
    cmd.op      = ALU_MUL;
    cmd.shift   = MEAN_SHIFT;
    cmd.cap     = QUOT_CAP;
    obs.ready   = 1'b0;
    emit_load   = 1'b0;
    alu_go      = 1'b0;
    case (state)
      ST_IDLE: begin
        obs.ready = 1'b1;
        if (obs.valid) begin
          if (count < CW'(MAX_OBS)) state_next = ST_SUM;
          else if (obs.item.last_obs) state_next = ST_SPA;
        end
      end
      ST_SUM: state_next = ST_MSQ;
      ST_MSQ: begin
        alu_go = 1'b1;
        cmd.a  = 128'(d);
        cmd.b  = 128'(d);
        if (rsp.done) begin
          state_next = ST_MDO;
          j_next     = 2'd0;
        end
      end
      ST_MDO: begin
        alu_go = 1'b1;
        cmd.a  = 128'(dir_sel);
        cmd.b  = 128'(d);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = item.last_obs ? ST_SPA : ST_IDLE;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_SPA: begin
        alu_go = 1'b1;
        cmd.a  = 128'(n64);
        cmd.b  = 128'(soq);
        if (rsp.done) state_next = ST_SPB;
      end
      ST_SPB: begin
        alu_go = 1'b1;
        cmd.a  = 128'(so);
        cmd.b  = 128'(so);
        if (rsp.done) state_next = ST_STAT;
      end
      ST_STAT: begin
        j_next     = 2'd0;
        state_next = (status_c != STAT_OK) ? ST_LOAD : ST_NA;
      end
      ST_NA: begin
        alu_go = 1'b1;
        cmd.a  = 128'(n64);
        cmd.b  = 128'(sdo[j]);
        if (rsp.done) state_next = ST_NB;
      end
      ST_NB: begin
        alu_go = 1'b1;
        cmd.a  = 128'(sd[j]);
        cmd.b  = 128'(so);
        if (rsp.done) state_next = ST_ETA;
      end
      ST_ETA: begin
        alu_go    = 1'b1;
        cmd.op    = ALU_DIV;
        cmd.a     = tmpa;
        cmd.b     = spread;
        cmd.shift = RATE_SHIFT;
        cmd.cap   = RATE_CAP;
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_Q2;
          end else begin
            j_next     = j + 2'd1;
            state_next = ST_NA;
          end
        end
      end
      ST_Q2: begin
        alu_go = 1'b1;
        cmd.a  = 128'(sd[j]);
        cmd.b  = 128'(sd[j]);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_SQRT;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_SQRT: begin
        alu_go = 1'b1;
        cmd.op = ALU_SQRT;
        cmd.a  = {q2[87:0], 40'b0};
        if (rsp.done) state_next = ST_UNIT;
      end
      ST_UNIT: begin
        cmd.op    = ALU_DIV;
        cmd.a     = 128'(sd[j]);
        cmd.b     = {67'b0, len};
        cmd.shift = UNIT_SHIFT;
        alu_go    = len != '0;
        if (rsp.done || len == '0) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_DOT;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_DOT: begin
        alu_go = 1'b1;
        cmd.a  = 128'(u[j]);
        cmd.b  = 128'(eta[j]);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_P;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_P: begin
        j_next     = 2'd0;
        state_next = ST_PERP;
      end
      ST_PERP: begin
        alu_go = 1'b1;
        cmd.a  = 128'(p);
        cmd.b  = 128'(u[j]);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_TM;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_TM: begin
        alu_go = 1'b1;
        cmd.op = ALU_DIV;
        cmd.a  = 128'(so);
        cmd.b  = 128'(n64);
        if (rsp.done) begin
          j_next     = 2'd0;
          state_next = ST_MP;
        end
      end
      ST_MP: begin
        alu_go = 1'b1;
        cmd.op = ALU_DIV;
        cmd.a  = 128'(sp[j]);
        cmd.b  = 128'(n64);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_MV;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_MV: begin
        alu_go = 1'b1;
        cmd.op = ALU_DIV;
        cmd.a  = 128'(sv[j]);
        cmd.b  = 128'(n64);
        if (rsp.done) begin
          if (j_last) begin
            j_next     = 2'd0;
            state_next = ST_LOAD;
          end else begin
            j_next = j + 2'd1;
          end
        end
      end
      ST_LOAD: begin
        if (!emit_busy) begin
          emit_load  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    if (alu_go && !issued) begin
      cmd.start   = 1'b1;
      issued_next = 1'b1;
    end
    if (rsp.done) issued_next = 1'b0;
  end

  // Running sums and the end-of-tracklet clear.
  always_ff @(posedge clk) begin
    if (rst || (state == ST_LOAD && !emit_busy)) begin
      first <= '0;
      count <= '0;
      ovf   <= 1'b0;
      so    <= '0;
      soq   <= '0;
      for (int k = 0; k < 3; k++) begin
        sd[k]  <= '0;
        sdo[k] <= '0;
        sp[k]  <= '0;
        sv[k]  <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (obs.valid && count >= CW'(MAX_OBS)) ovf <= 1'b1;
        end
        ST_SUM: begin
          if (count == '0) first <= item.obs_time;
          count <= count + CW'(1);
          so    <= sat_w(129'(so) + 129'(d_c), 64);
          sd[0] <= 40'(sat_w(129'(sd[0]) + 129'(item.dir_x), 40));
          sd[1] <= 40'(sat_w(129'(sd[1]) + 129'(item.dir_y), 40));
          sd[2] <= 40'(sat_w(129'(sd[2]) + 129'(item.dir_z), 40));
          sp[0] <= 56'(sat_w(129'(sp[0]) + 129'(item.pos_x), 56));
          sp[1] <= 56'(sat_w(129'(sp[1]) + 129'(item.pos_y), 56));
          sp[2] <= 56'(sat_w(129'(sp[2]) + 129'(item.pos_z), 56));
          sv[0] <= 56'(sat_w(129'(sv[0]) + 129'(item.vel_x), 56));
          sv[1] <= 56'(sat_w(129'(sv[1]) + 129'(item.vel_y), 56));
          sv[2] <= 56'(sat_w(129'(sv[2]) + 129'(item.vel_z), 56));
        end
        ST_MSQ: begin
          if (rsp.done) soq <= sat_w(129'(soq) + 129'(rsp.res), 64);
        end
        ST_MDO: begin
          if (rsp.done) sdo[j] <= sat_w(129'(sdo[j]) + 129'(rsp.res), 64);
        end
        default: begin
        end
      endcase
    end
  end

  // Observation holding register and closing fit results.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (obs.valid) item <= obs.item;
      end
      ST_SUM: d <= d_c;
      ST_SPA: begin
        if (rsp.done) tmpa <= rsp.res;
      end
      ST_SPB: begin
        if (rsp.done) spread <= tmpa - rsp.res;
      end
      ST_STAT: begin
        status <= status_c;
        q2     <= '0;
        dot    <= '0;
      end
      ST_NA: begin
        if (rsp.done) tmpa <= rsp.res;
      end
      ST_NB: begin
        if (rsp.done) tmpa <= tmpa - rsp.res;
      end
      ST_ETA: begin
        if (rsp.done) eta[j] <= rsp.res[61:0];
      end
      ST_Q2: begin
        if (rsp.done) q2 <= q2 + rsp.res;
      end
      ST_SQRT: begin
        if (rsp.done) len <= rsp.res[60:0];
      end
      ST_UNIT: begin
        if (len == '0) u[j] <= '0;
        else if (rsp.done) u[j] <= 32'(sat_w(129'(rsp.res), 32));
      end
      ST_DOT: begin
        if (rsp.done) dot <= dot + rsp.res;
      end
      ST_P: p <= sat_w(rnd30(dot), 64);
      ST_PERP: begin
        if (rsp.done) perp[j] <= 48'(sat_w(129'(eta[j]) - rnd30(rsp.res), 48));
      end
      ST_TM: begin
        if (rsp.done) tm <= 48'(sat_w(129'(first) + 129'(rsp.res), 48));
      end
      ST_MP: begin
        if (rsp.done) mp[j] <= 48'(sat_w(129'(rsp.res), 48));
      end
      ST_MV: begin
        if (rsp.done) mv[j] <= 48'(sat_w(129'(rsp.res), 48));
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hw/rtl/taf_checker.sv -----
// Port-level checks of the tracklet attributable fit unit, bound to the top level.
module taf_checker import taf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      obs_valid,
  input logic      obs_ready,
  input logic      fit_valid,
  input logic      fit_ready,
  input out_item_t fit_item
);

  logic obs_beat;
  assign obs_beat = obs_valid && obs_ready;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    fit_valid && !fit_ready |=> fit_valid && $stable(fit_item))
    else $error("result beat changed or dropped while stalled");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_item.status != STAT_OK |->
      fit_item.last_result && fit_item.mean_time == '0 && fit_item.los_rate == '0)
    else $error("error result is not a single zeroed beat");

  a_z_last: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_item.axis == AXIS_Z |-> fit_item.last_result)
    else $error("z result not marked last");

  a_run_on: assert property (@(posedge clk) disable iff (rst)
    fit_valid && fit_ready && !fit_item.last_result |=> fit_valid)
    else $error("gap inside a tracklet's results");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    obs_beat && fit_valid && !fit_ready |=> fit_valid)
    else $error("pending result lost when an observation was taken");

endmodule

bind tracklet_attributable_fit_unit taf_checker u_taf_checker (
  .clk       (clk),
  .rst       (rst),
  .obs_valid (obs.valid),
  .obs_ready (obs.ready),
  .fit_valid (fit.valid),
  .fit_ready (fit.ready),
  .fit_item  (fit.item)
);
